[rtl/core/ddg_pkg.sv]
// Shared constants, types and tables of the go-to-goal motion controller.
`timescale 1ns / 1ps

package ddg_pkg;

	localparam int POS_WIDTH   = 24;
	localparam int SPEED_LIMIT = 60;

	localparam int HEAD_W  = 9;
	localparam int SPD_W   = 7;
	localparam int MODE_W  = 2;
	localparam int ACT_W   = 3;
	localparam int DIFF_W  = POS_WIDTH + 1;
	localparam int SQ_W    = 2 * POS_WIDTH + 1;
	localparam int DIST_W  = POS_WIDTH + 1;
	localparam int TURN_W  = 12;

	// Shared divider: dividend and divisor widths.
	localparam int DIV_N   = 24;
	localparam int DIV_D   = 16;

	// CORDIC datapath.
	localparam int CX_W        = 36;
	localparam int Z_W         = 25;
	localparam int CORDIC_ITER = 23;
	localparam int ATAN_W      = 22;

	// Stream packing.
	localparam int OFS_TY      = POS_WIDTH;
	localparam int OFS_TH      = 2 * POS_WIDTH;
	localparam int OFS_RX      = 2 * POS_WIDTH + HEAD_W;
	localparam int OFS_RY      = 3 * POS_WIDTH + HEAD_W;
	localparam int OFS_RH      = 4 * POS_WIDTH + HEAD_W;
	localparam int IN_FIELDS_W = 4 * POS_WIDTH + 2 * HEAD_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_W       = 2 * SPD_W + MODE_W + 1;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_ROT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ROT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_PPS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALT_DIST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL     = 3'd5;

	localparam logic [ACT_W-1:0] ACT_TICK = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ROT  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FWD  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_BACK = 3'd3;
	localparam logic [ACT_W-1:0] ACT_HALT = 3'd4;

	localparam logic [MODE_W-1:0] MODE_HALT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BACK = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ROT  = 2'd3;

	typedef struct packed {
		logic             start;
		logic [DIV_N-1:0] dividend;
		logic [DIV_D-1:0] divisor;
	} div_req_t;

	// Arctangent of 2^-i in units of 2^-16 degree.
	function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] i);
		logic [ATAN_W-1:0] v;
		begin
			unique case (i)
				5'd0:  v = 22'd2949120;
				5'd1:  v = 22'd1740967;
				5'd2:  v = 22'd919879;
				5'd3:  v = 22'd466945;
				5'd4:  v = 22'd234379;
				5'd5:  v = 22'd117304;
				5'd6:  v = 22'd58666;
				5'd7:  v = 22'd29335;
				5'd8:  v = 22'd14668;
				5'd9:  v = 22'd7334;
				5'd10: v = 22'd3667;
				5'd11: v = 22'd1833;
				5'd12: v = 22'd917;
				5'd13: v = 22'd458;
				5'd14: v = 22'd229;
				5'd15: v = 22'd115;
				5'd16: v = 22'd57;
				5'd17: v = 22'd29;
				5'd18: v = 22'd14;
				5'd19: v = 22'd7;
				5'd20: v = 22'd4;
				5'd21: v = 22'd2;
				5'd22: v = 22'd1;
				default: v = '0;
			endcase
			atan_lut = v;
		end
	endfunction

endpackage

[rtl/core/ddg_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ddg_div import ddg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [DIV_N-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_N);

	logic             busy_q;
	logic             fin_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_D:0]   rem_q;
	logic [DIV_N-1:0] q_q;
	logic [DIV_D-1:0] dvs_q;
	logic [DIV_D:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q[DIV_D-1:0], q_q[DIV_N-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};
	assign done   = fin_q;
	assign quot   = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_N - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			q_q   <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			q_q   <= {q_q[DIV_N-2:0], fits};
		end
	end

endmodule

[rtl/core/ddg_isqrt.sv]
// Digit-by-digit integer square root, rounded to nearest.
`timescale 1ns / 1ps

module ddg_isqrt import ddg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   val,
	output logic              done,
	output logic [DIST_W-1:0] root
);

	localparam int SP_W  = 2 * DIST_W;
	localparam int REM_W = DIST_W + 3;
	localparam int CNT_W = $clog2(DIST_W);

	logic              busy_q;
	logic              fin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SP_W-1:0]   s_q;
	logic [DIST_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign rem_sh = {rem_q[REM_W-3:0], s_q[SP_W-1:SP_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = rem_sh >= trial;
	assign done   = fin_q;
	// The remainder is value minus root squared; round up when it exceeds the root.
	assign root   = root_q + DIST_W'(rem_q > {3'b000, root_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIST_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q    <= {{(SP_W - SQ_W){1'b0}}, val};
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			s_q    <= {s_q[SP_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[DIST_W-2:0], fits};
		end
	end

endmodule

[rtl/core/ddg_cordic.sv]
// Iterative CORDIC vectoring unit giving the bearing in whole degrees.
`timescale 1ns / 1ps

module ddg_cordic import ddg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [POS_WIDTH-1:0]     abs_x,
	input  logic [POS_WIDTH-1:0]     abs_y,
	input  logic                     neg_x,
	input  logic                     neg_y,
	output logic                     done,
	output logic signed [HEAD_W-1:0] bearing
);

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_NORM = 4'b0010,
		C_ITER = 4'b0100,
		C_OUT  = 4'b1000
	} cstate_t;

	cstate_t                state_q;
	logic signed [CX_W-1:0] x_q;
	logic signed [CX_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [4:0]             i_q;
	logic                   nx_q;
	logic                   ny_q;
	logic signed [CX_W-1:0] ys;
	logic signed [CX_W-1:0] xs;
	logic signed [Z_W-1:0]  ang;
	logic [Z_W-1:0]         zr;
	logic [6:0]             deg;
	logic [7:0]             quad;

	// Arithmetic shift that rounds toward zero.
	function automatic logic signed [CX_W-1:0] shr0(input logic signed [CX_W-1:0] v,
		input logic [4:0] s);
		logic [CX_W-1:0] m;
		begin
			m = v[CX_W-1] ? $unsigned(-v) : $unsigned(v);
			m = m >> s;
			shr0 = v[CX_W-1] ? -$signed(m) : $signed(m);
		end
	endfunction

	assign ys  = shr0(y_q, i_q);
	assign xs  = shr0(x_q, i_q);
	assign ang = $signed({{(Z_W - ATAN_W){1'b0}}, atan_lut(i_q)});

	always_comb begin
		zr = $unsigned(z_q) + Z_W'(32768);
		if (z_q[Z_W-1]) begin
			deg = '0;
		end else if (zr[Z_W-1:16] > (Z_W - 16)'(90)) begin
			deg = 7'd90;
		end else begin
			deg = zr[22:16];
		end
		quad    = ny_q ? 8'd180 - {1'b0, deg} : {1'b0, deg};
		bearing = nx_q ? -$signed({1'b0, quad}) : $signed({1'b0, quad});
	end

	assign done = (state_q == C_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					i_q <= '0;
					if (start) begin
						state_q <= ((abs_x == '0) && (abs_y == '0)) ? C_OUT : C_NORM;
					end
				end
				C_NORM: begin
					if (x_q[30] || y_q[30]) begin
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (i_q == 5'(CORDIC_ITER - 1)) begin
						state_q <= C_OUT;
					end
					i_q <= i_q + 1'b1;
				end
				C_OUT: state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			x_q  <= $signed({{(CX_W - POS_WIDTH){1'b0}}, abs_y});
			y_q  <= $signed({{(CX_W - POS_WIDTH){1'b0}}, abs_x});
			z_q  <= '0;
			nx_q <= neg_x;
			ny_q <= neg_y;
		end else if (state_q == C_NORM) begin
			if (!(x_q[30] || y_q[30])) begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end
		end else if (state_q == C_ITER) begin
			if (!y_q[CX_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
		end
	end

endmodule

[rtl/core/diff_drive_goto_target_ctrl_core.sv]
// Top level of the differential-drive go-to-goal motion controller.
`timescale 1ns / 1ps

// Usage: each input transaction on the s_ side carries the robot pose from
// odometry and an action in s_tuser (tick, rotate, forward, backward, halt).
// Every accepted transaction yields exactly one output transaction on the m_
// side with the wheel speed commands, the motion mode after the item and an
// arrival flag. A rotate, forward or backward action issued while halted, and
// a tick while moving, run a full evaluation; other items only update state.
// Sequencing: an item that needs no evaluation goes straight to the done
// state, which raises m_tvalid. A point evaluation passes through the
// 25-step square root unit and, unless the goal is reached, the CORDIC unit
// (up to 30 normalize steps plus 23 iterations) and up to four passes of the
// shared divider; a rotation evaluation skips the square root and CORDIC units.
// One item is worked on at a time; s_tready is low while an item is in
// flight. A result waits in the output register while the receiver stalls,
// and the next item is taken at the edge where that result is taken.
// Reset clears the mode to halted, the stored goal and speeds to zero, and
// loads the default register values. Register writes are taken at any edge
// with cfg_we high and must only be issued while the block is idle.

module diff_drive_goto_target_ctrl_core import ddg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// target_x, target_y, target_heading, robot_x, robot_y, robot_heading, zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// action
	input  logic [ACT_W-1:0]       s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// left_speed, right_speed, motion_mode, arrived, zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [14:0] {
		S_IDLE    = 15'b000000000000001,
		S_SQA     = 15'b000000000000010,
		S_SQB     = 15'b000000000000100,
		S_SQRT    = 15'b000000000001000,
		S_DIST    = 15'b000000000010000,
		S_CORDIC  = 15'b000000000100000,
		S_TURN    = 15'b000000001000000,
		S_ROT     = 15'b000000010000000,
		S_ROTDIV  = 15'b000000100000000,
		S_LIN     = 15'b000001000000000,
		S_LINDIV  = 15'b000010000000000,
		S_MIX     = 15'b000100000000000,
		S_MIXL    = 15'b001000000000000,
		S_MIXR    = 15'b010000000000000,
		S_DONE    = 15'b100000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [7:0]  min_rot_q, max_rot_q, rot_pps_q, max_speed_q;
	logic [15:0] halt_dist_q, decel_q;

	// Controller state.
	logic [MODE_W-1:0]           mode_q;
	logic signed [POS_WIDTH-1:0] goal_x_q, goal_y_q;
	logic signed [HEAD_W-1:0]    goal_h_q;
	logic signed [SPD_W-1:0]     left_q, right_q;
	logic                        arrived_q;

	// Item and working registers.
	logic signed [POS_WIDTH-1:0] rx_q, ry_q;
	logic signed [HEAD_W-1:0]    rh_q;
	logic [SQ_W-1:0]             acc_q;
	logic [DIST_W-1:0]           dist_q;
	logic signed [HEAD_W-1:0]    bearing_q;
	logic [7:0]                  at_q;
	logic                        turn_neg_q;
	logic signed [8:0]           rot_q, lin_q;
	logic                        m_tvalid_q;
	logic [OUT_W-1:0]            out_q;

	logic accept;

	// Unpacked input fields.
	logic [ACT_W-1:0]            in_act;
	logic signed [POS_WIDTH-1:0] in_tx, in_ty, in_rx, in_ry;
	logic signed [HEAD_W-1:0]    in_th, in_rh;

	assign in_act = s_tuser;
	assign in_tx  = $signed(s_tdata[0 +: POS_WIDTH]);
	assign in_ty  = $signed(s_tdata[OFS_TY +: POS_WIDTH]);
	assign in_th  = $signed(s_tdata[OFS_TH +: HEAD_W]);
	assign in_rx  = $signed(s_tdata[OFS_RX +: POS_WIDTH]);
	assign in_ry  = $signed(s_tdata[OFS_RY +: POS_WIDTH]);
	assign in_rh  = $signed(s_tdata[OFS_RH +: HEAD_W]);

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_q};

	// Offset from robot to goal and its magnitude.
	logic signed [DIFF_W-1:0] dx, dy;
	logic [DIFF_W-1:0]        adx_f, ady_f;
	logic [POS_WIDTH-1:0]     adx, ady, mul_op;
	logic [2*POS_WIDTH-1:0]   mul_p;
	logic [SQ_W-1:0]          sq_sum;

	assign dx     = $signed({goal_x_q[POS_WIDTH-1], goal_x_q}) - $signed({rx_q[POS_WIDTH-1], rx_q});
	assign dy     = $signed({goal_y_q[POS_WIDTH-1], goal_y_q}) - $signed({ry_q[POS_WIDTH-1], ry_q});
	assign adx_f  = dx[DIFF_W-1] ? $unsigned(-dx) : $unsigned(dx);
	assign ady_f  = dy[DIFF_W-1] ? $unsigned(-dy) : $unsigned(dy);
	assign adx    = adx_f[POS_WIDTH-1:0];
	assign ady    = ady_f[POS_WIDTH-1:0];
	assign mul_op = (state_q == S_SQA) ? adx : ady;
	assign mul_p  = mul_op * mul_op;
	assign sq_sum = acc_q + {1'b0, mul_p};

	// Heading error, wrapped into [-180, 180).
	function automatic logic signed [HEAD_W-1:0] wrap_deg(input logic signed [TURN_W-1:0] v);
		logic signed [TURN_W-1:0] w;
		begin
			w = v + TURN_W'(720);
			if (w >= TURN_W'(720)) w = w - TURN_W'(720);
			if (w >= TURN_W'(360)) w = w - TURN_W'(360);
			if (w >= TURN_W'(180)) w = w - TURN_W'(360);
			wrap_deg = w[HEAD_W-1:0];
		end
	endfunction

	logic signed [TURN_W-1:0] ref_h, turn_raw;
	logic signed [HEAD_W-1:0] turn;
	logic [HEAD_W-1:0]        turn_abs;
	logic [7:0]               at;

	always_comb begin
		ref_h    = (mode_q == MODE_ROT) ? TURN_W'(goal_h_q) : TURN_W'(bearing_q);
		turn_raw = ref_h - TURN_W'(rh_q);
		if (mode_q == MODE_BACK) begin
			turn_raw = turn_raw - TURN_W'(180);
		end
		turn     = wrap_deg(turn_raw);
		turn_abs = turn[HEAD_W-1] ? $unsigned(-turn) : $unsigned(turn);
		at       = turn_abs[7:0];
	end

	// Speed decisions.
	logic rot_full, rot_zero, lin_zero, lin_ramp;
	assign rot_full = at_q > max_rot_q;
	assign rot_zero = max_rot_q == '0;
	assign lin_zero = (mode_q == MODE_ROT) || rot_full;
	assign lin_ramp = dist_q < {{(DIST_W - 16){1'b0}}, decel_q};

	logic [15:0] rot_prod;
	logic [23:0] lin_prod;
	assign rot_prod = at_q * rot_pps_q;
	assign lin_prod = max_speed_q * dist_q[15:0];

	// Wheel mixing terms.
	logic signed [8:0] lin_abs_s, rot_abs_s;
	logic [8:0]        mx;
	logic [6:0]        rel;
	logic signed [9:0] sum_s, dif_s;
	logic [9:0]        sum_abs, dif_abs;
	logic [15:0]       mixl_prod, mixr_prod;

	always_comb begin
		lin_abs_s = lin_q[8] ? -lin_q : lin_q;
		rot_abs_s = rot_q[8] ? -rot_q : rot_q;
		mx        = $unsigned(lin_abs_s) + $unsigned(rot_abs_s);
		rel       = (mx < 9'(SPEED_LIMIT)) ? mx[6:0] : 7'(SPEED_LIMIT);
		sum_s     = {lin_q[8], lin_q} + {rot_q[8], rot_q};
		dif_s     = {lin_q[8], lin_q} - {rot_q[8], rot_q};
		sum_abs   = sum_s[9] ? $unsigned(-sum_s) : $unsigned(sum_s);
		dif_abs   = dif_s[9] ? $unsigned(-dif_s) : $unsigned(dif_s);
		mixl_prod = sum_abs[8:0] * rel;
		mixr_prod = dif_abs[8:0] * rel;
	end

	// Shared units.
	div_req_t          div_req;
	logic              div_done;
	logic [DIV_N-1:0]  div_quot;
	logic              sq_done;
	logic [DIST_W-1:0] sq_dist;
	logic              cor_done;
	logic signed [HEAD_W-1:0] cor_bearing;

	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_ROT: begin
				div_req.start    = !rot_full && !rot_zero;
				div_req.dividend = DIV_N'(rot_prod);
				div_req.divisor  = DIV_D'(max_rot_q);
			end
			S_LIN: begin
				div_req.start    = !lin_zero && lin_ramp;
				div_req.dividend = lin_prod;
				div_req.divisor  = decel_q;
			end
			S_MIX: begin
				div_req.start    = mx != '0;
				div_req.dividend = DIV_N'(mixl_prod);
				div_req.divisor  = DIV_D'(mx);
			end
			S_MIXL: begin
				div_req.start    = div_done;
				div_req.dividend = DIV_N'(mixr_prod);
				div_req.divisor  = DIV_D'(mx);
			end
			default: div_req = '0;
		endcase
	end

	ddg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	ddg_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SQB),
		.val    (sq_sum),
		.done   (sq_done),
		.root   (sq_dist)
	);

	logic sq_dist_gt_halt;
	assign sq_dist_gt_halt = dist_q > {{(DIST_W - 16){1'b0}}, halt_dist_q};

	ddg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   ((state_q == S_DIST) && (sq_dist_gt_halt)),
		.abs_x   (adx),
		.abs_y   (ady),
		.neg_x   (dx[DIFF_W-1]),
		.neg_y   (dy[DIFF_W-1]),
		.done    (cor_done),
		.bearing (cor_bearing)
	);

	// Quotient magnitudes; the sign is applied where they are stored.
	logic signed [8:0]       q9;
	logic signed [SPD_W-1:0] q7;
	assign q9 = $signed({1'b0, div_quot[7:0]});
	assign q7 = $signed(div_quot[SPD_W-1:0]);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rot_q   <= 8'd3;
			max_rot_q   <= 8'd30;
			rot_pps_q   <= 8'd10;
			max_speed_q <= 8'd60;
			halt_dist_q <= 16'd20;
			decel_q     <= 16'd200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_ROT:   min_rot_q   <= cfg_data[7:0];
				REG_MAX_ROT:   max_rot_q   <= cfg_data[7:0];
				REG_ROT_PPS:   rot_pps_q   <= cfg_data[7:0];
				REG_MAX_SPEED: max_speed_q <= cfg_data[7:0];
				REG_HALT_DIST: halt_dist_q <= cfg_data;
				REG_DECEL:     decel_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_HALT;
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			goal_h_q   <= '0;
			left_q     <= '0;
			right_q    <= '0;
			arrived_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						arrived_q <= 1'b0;
						state_q   <= S_DONE;
						unique case (in_act)
							ACT_TICK: begin
								if (mode_q == MODE_ROT) begin
									state_q <= S_TURN;
								end else if (mode_q != MODE_HALT) begin
									state_q <= S_SQA;
								end
							end
							ACT_ROT: begin
								goal_h_q <= in_th;
								if (mode_q == MODE_HALT) begin
									mode_q  <= MODE_ROT;
									state_q <= S_TURN;
								end
							end
							ACT_FWD, ACT_BACK: begin
								goal_x_q <= in_tx;
								goal_y_q <= in_ty;
								mode_q   <= (in_act == ACT_FWD) ? MODE_FWD : MODE_BACK;
								if (mode_q == MODE_HALT) begin
									state_q <= S_SQA;
								end
							end
							ACT_HALT: begin
								mode_q  <= MODE_HALT;
								left_q  <= '0;
								right_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SQA:  state_q <= S_SQB;
				S_SQB:  state_q <= S_SQRT;
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					if (!sq_dist_gt_halt) begin
						mode_q    <= MODE_HALT;
						left_q    <= '0;
						right_q   <= '0;
						arrived_q <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_CORDIC;
					end
				end
				S_CORDIC: begin
					if (cor_done) begin
						state_q <= S_TURN;
					end
				end
				S_TURN: begin
					if ((mode_q == MODE_ROT) && (at <= min_rot_q)) begin
						mode_q    <= MODE_HALT;
						left_q    <= '0;
						right_q   <= '0;
						arrived_q <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					state_q <= (rot_full || rot_zero) ? S_LIN : S_ROTDIV;
				end
				S_ROTDIV: begin
					if (div_done) begin
						state_q <= S_LIN;
					end
				end
				S_LIN: begin
					state_q <= (!lin_zero && lin_ramp) ? S_LINDIV : S_MIX;
				end
				S_LINDIV: begin
					if (div_done) begin
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					if (mx == '0) begin
						left_q  <= '0;
						right_q <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MIXL;
					end
				end
				S_MIXL: begin
					if (div_done) begin
						left_q  <= sum_s[9] ? -q7 : q7;
						state_q <= S_MIXR;
					end
				end
				S_MIXR: begin
					if (div_done) begin
						right_q <= dif_s[9] ? -q7 : q7;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					m_tvalid_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_q <= in_rx;
			ry_q <= in_ry;
			rh_q <= in_rh;
		end
		if (state_q == S_SQA) begin
			acc_q <= {1'b0, mul_p};
		end
		if (state_q == S_SQRT && sq_done) begin
			dist_q <= sq_dist;
		end
		if (state_q == S_CORDIC && cor_done) begin
			bearing_q <= cor_bearing;
		end
		if (state_q == S_TURN) begin
			at_q       <= at;
			turn_neg_q <= turn[HEAD_W-1];
		end
		if (state_q == S_ROT) begin
			if (rot_full) begin
				rot_q <= turn_neg_q ? -$signed({1'b0, rot_pps_q}) : $signed({1'b0, rot_pps_q});
			end else if (rot_zero) begin
				rot_q <= '0;
			end
		end
		if (state_q == S_ROTDIV && div_done) begin
			rot_q <= turn_neg_q ? -q9 : q9;
		end
		if (state_q == S_LIN) begin
			if (lin_zero) begin
				lin_q <= '0;
			end else if (!lin_ramp) begin
				lin_q <= (mode_q == MODE_BACK) ? -$signed({1'b0, max_speed_q})
					: $signed({1'b0, max_speed_q});
			end
		end
		if (state_q == S_LINDIV && div_done) begin
			lin_q <= (mode_q == MODE_BACK) ? -q9 : q9;
		end
		if (state_q == S_DONE) begin
			out_q <= {arrived_q, mode_q, right_q, left_q};
		end
	end

endmodule
